// ===== sv/arpc_pkg.sv =====
// arpc_pkg: shared types and header constants for the ARP receive block.
// No dependencies; used by the cache cells and the top level.
package arpc_pkg;

	// item kinds
	localparam logic OPC_FRAME  = 1'b0;
	localparam logic OPC_LOOKUP = 1'b1;

	// header checks
	localparam logic [15:0] MIN_FRAME_LEN  = 16'(14 + 28);
	localparam logic [15:0] ETYPE_ARP      = 16'h0806;
	localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
	localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
	localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
	localparam logic [15:0] OPER_REQUEST   = 16'd1;

	// search token passed from cell to cell
	typedef struct packed {
		logic        valid;
		logic [31:0] ip;
		logic        hit;
		logic        free;
		logic [47:0] mac;
	} tok_t;

	// cache write broadcast to all cells
	typedef struct packed {
		logic        en;
		logic [31:0] ip;
		logic [47:0] mac;
	} wr_t;

	// captured input word
	typedef struct packed {
		logic        opcode;
		logic [15:0] frame_length;
		logic [15:0] ethertype;
		logic [15:0] proto_type;
		logic [7:0]  hw_len;
		logic [7:0]  proto_len;
		logic [15:0] arp_oper;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] tgt_ip;
		logic [31:0] query_ip;
	} item_t;

endpackage

// ===== sv/arpc_if.sv =====
// arpc_if: valid/ready channel interfaces for input and result words.
// No dependencies.
interface arpc_item_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] frame_length;
	logic [15:0] ethertype;
	logic [15:0] proto_type;
	logic [7:0]  hw_len;
	logic [7:0]  proto_len;
	logic [15:0] arp_oper;
	logic [47:0] sender_mac;
	logic [31:0] sender_ip;
	logic [31:0] tgt_ip;
	logic [31:0] query_ip;

	modport source (output valid, opcode, frame_length, ethertype, proto_type, hw_len,
		proto_len, arp_oper, sender_mac, sender_ip, tgt_ip, query_ip, input ready);
	modport sink (input valid, opcode, frame_length, ethertype, proto_type, hw_len,
		proto_len, arp_oper, sender_mac, sender_ip, tgt_ip, query_ip, output ready);
endinterface

interface arpc_result_if;
	logic        valid;
	logic        ready;
	logic        consumed;
	logic        learned;
	logic        reply_needed;
	logic [47:0] reply_mac;
	logic [31:0] reply_ip;
	logic        hit;
	logic [47:0] found_mac;

	modport source (output valid, consumed, learned, reply_needed, reply_mac, reply_ip,
		hit, found_mac, input ready);
	modport sink (input valid, consumed, learned, reply_needed, reply_mac, reply_ip,
		hit, found_mac, output ready);
endinterface

// ===== sv/arpc_cell.sv =====
// arpc_cell: one cache entry plus one stage of the search chain.
// Depends on arpc_pkg.
module arpc_cell #(
	parameter int IDX    = 0,
	parameter int SLOT_W = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  arpc_pkg::tok_t     prev_tok,
	input  logic [SLOT_W-1:0]  prev_hit_slot,
	input  logic [SLOT_W-1:0]  prev_free_slot,
	output arpc_pkg::tok_t     next_tok,
	output logic [SLOT_W-1:0]  next_hit_slot,
	output logic [SLOT_W-1:0]  next_free_slot,
	input  arpc_pkg::wr_t      wr,
	input  logic [SLOT_W-1:0]  wr_slot
);
	import arpc_pkg::*;

	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

	logic [31:0] ent_ip_q;
	logic [47:0] ent_mac_q;
	logic        ent_valid_q;
	logic        tok_valid_q;
	tok_t        tok_q;
	logic [SLOT_W-1:0] hit_slot_q;
	logic [SLOT_W-1:0] free_slot_q;
	tok_t        tok_d;
	logic [SLOT_W-1:0] hit_slot_d;
	logic [SLOT_W-1:0] free_slot_d;
	logic        match;
	logic        take_free;

	// first valid match wins; first empty entry noted for learning
	assign match     = !prev_tok.hit && ent_valid_q && (ent_ip_q == prev_tok.ip);
	assign take_free = !prev_tok.hit && !prev_tok.free && !ent_valid_q;

	always_comb begin
		tok_d       = prev_tok;
		hit_slot_d  = prev_hit_slot;
		free_slot_d = prev_free_slot;
		if (match) begin
			tok_d.hit  = 1'b1;
			tok_d.mac  = ent_mac_q;
			hit_slot_d = MY_SLOT;
		end
		if (take_free) begin
			tok_d.free  = 1'b1;
			free_slot_d = MY_SLOT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= prev_tok.valid;
			if (wr.en && wr_slot == MY_SLOT) begin
				ent_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr_slot == MY_SLOT) begin
			ent_ip_q  <= wr.ip;
			ent_mac_q <= wr.mac;
		end
		tok_q       <= tok_d;
		hit_slot_q  <= hit_slot_d;
		free_slot_q <= free_slot_d;
	end

	always_comb begin
		next_tok       = tok_q;
		next_tok.valid = tok_valid_q;
	end
	assign next_hit_slot  = hit_slot_q;
	assign next_free_slot = free_slot_q;

endmodule

// ===== sv/arp_receive_and_cache.sv =====
// ARP receive engine with a fully associative IPv4-to-MAC cache of ENTRIES
// entries. Each input word is a parsed ARP frame or a cache lookup and gives
// exactly one result word. The cache is a row of cells, one entry each; a
// search token enters the first cell when a word is accepted and moves one
// cell per clock, so it reaches the end of the row and is captured there;
// the commit that follows writes the cache and loads the result register.
// One word is in work at a time: the next word can be accepted on the
// cycle after the result is loaded. A pending result does not block
// acceptance of the next word, but that word's commit waits until the
// pending result drains.
// Learning overwrites a matching valid entry, else the lowest empty entry,
// else entry 0. The valid bits clear on reset; our_ip resets to 0 and is
// written through cfg_we/cfg_wdata. The user must write it only while the
// block is idle; the block itself does not enforce this.
// Depends on arpc_pkg, arpc_if (interfaces) and arpc_cell.
module arp_receive_and_cache #(
	parameter int ENTRIES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata,
	arpc_item_if.sink            item,
	arpc_result_if.source        result
);
	import arpc_pkg::*;

	localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]  state_q;
	logic [31:0] our_ip_q;
	item_t       item_q;
	logic        accept;

	// chain wiring: index k feeds cell k
	tok_t              tok_c       [0:ENTRIES];
	logic [SLOT_W-1:0] hit_slot_c  [0:ENTRIES];
	logic [SLOT_W-1:0] free_slot_c [0:ENTRIES];

	// token captured at chain end
	logic              tok_hit_q;
	logic              tok_free_q;
	logic [47:0]       tok_mac_q;
	logic [SLOT_W-1:0] hit_slot_q;
	logic [SLOT_W-1:0] free_slot_q;

	// result register
	logic        res_valid_q;
	logic        res_consumed_q;
	logic        res_learned_q;
	logic        res_reply_q;
	logic [47:0] res_reply_mac_q;
	logic [31:0] res_reply_ip_q;
	logic        res_hit_q;
	logic [47:0] res_found_mac_q;

	// decode of the word in work
	logic        is_lookup;
	logic        frame_ok;
	logic        fmt_ok;
	logic        do_learn;
	logic        do_reply;
	logic        commit;
	wr_t         wr;
	logic [SLOT_W-1:0] wr_slot;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;

	// launch the search key into the first cell on accept
	assign tok_c[0].valid = accept;
	assign tok_c[0].ip    = (item.opcode == OPC_LOOKUP) ? item.query_ip : item.sender_ip;
	assign tok_c[0].hit   = 1'b0;
	assign tok_c[0].free  = 1'b0;
	assign tok_c[0].mac   = '0;
	assign hit_slot_c[0]  = '0;
	assign free_slot_c[0] = '0;

	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		arpc_cell #(
			.IDX    (k),
			.SLOT_W (SLOT_W)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.prev_tok       (tok_c[k]),
			.prev_hit_slot  (hit_slot_c[k]),
			.prev_free_slot (free_slot_c[k]),
			.next_tok       (tok_c[k+1]),
			.next_hit_slot  (hit_slot_c[k+1]),
			.next_free_slot (free_slot_c[k+1]),
			.wr             (wr),
			.wr_slot        (wr_slot)
		);
	end

	// header checks on the captured word
	assign is_lookup = (item_q.opcode == OPC_LOOKUP);
	assign frame_ok  = !is_lookup && (item_q.frame_length >= MIN_FRAME_LEN)
		&& (item_q.ethertype == ETYPE_ARP);
	assign fmt_ok    = (item_q.proto_type == PTYPE_IPV4) && (item_q.hw_len == HW_ADDR_LEN)
		&& (item_q.proto_len == PROTO_ADDR_LEN);
	assign do_learn  = frame_ok && fmt_ok;
	assign do_reply  = do_learn && (item_q.arp_oper == OPER_REQUEST)
		&& (item_q.tgt_ip == our_ip_q);

	// finish when the result register is free or being drained
	assign commit = (state_q == ST_DONE) && (!res_valid_q || result.ready);

	always_comb begin
		wr.en  = commit && do_learn;
		wr.ip  = item_q.sender_ip;
		wr.mac = item_q.sender_mac;
		// match slot, else lowest empty slot, else evict slot 0
		if (tok_hit_q) begin
			wr_slot = hit_slot_q;
		end else if (tok_free_q) begin
			wr_slot = free_slot_q;
		end else begin
			wr_slot = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			our_ip_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				our_ip_q <= cfg_wdata;
			end
			// a new result replaces one leaving in the same cycle
			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok_c[ENTRIES].valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.opcode       <= item.opcode;
			item_q.frame_length <= item.frame_length;
			item_q.ethertype    <= item.ethertype;
			item_q.proto_type   <= item.proto_type;
			item_q.hw_len       <= item.hw_len;
			item_q.proto_len    <= item.proto_len;
			item_q.arp_oper     <= item.arp_oper;
			item_q.sender_mac   <= item.sender_mac;
			item_q.sender_ip    <= item.sender_ip;
			item_q.tgt_ip       <= item.tgt_ip;
			item_q.query_ip     <= item.query_ip;
		end
		if (state_q == ST_SCAN && tok_c[ENTRIES].valid) begin
			tok_hit_q   <= tok_c[ENTRIES].hit;
			tok_free_q  <= tok_c[ENTRIES].free;
			tok_mac_q   <= tok_c[ENTRIES].mac;
			hit_slot_q  <= hit_slot_c[ENTRIES];
			free_slot_q <= free_slot_c[ENTRIES];
		end
		if (commit) begin
			res_consumed_q  <= frame_ok;
			res_learned_q   <= do_learn;
			res_reply_q     <= do_reply;
			res_reply_mac_q <= do_reply ? item_q.sender_mac : 48'd0;
			res_reply_ip_q  <= do_reply ? item_q.sender_ip : 32'd0;
			res_hit_q       <= is_lookup && tok_hit_q;
			res_found_mac_q <= (is_lookup && tok_hit_q) ? tok_mac_q : 48'd0;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.consumed     = res_consumed_q;
	assign result.learned      = res_learned_q;
	assign result.reply_needed = res_reply_q;
	assign result.reply_mac    = res_reply_mac_q;
	assign result.reply_ip     = res_reply_ip_q;
	assign result.hit          = res_hit_q;
	assign result.found_mac    = res_found_mac_q;

endmodule

// ===== tb/sv/arp_receive_and_cache_test.sv =====
// Self-checking bench for arp_receive_and_cache: frames and lookups go in, each result word
// is checked against a mirror of the IP-to-MAC cache kept by a small scoreboard class.
// Depends on arpc_pkg, arpc_if and the block itself.
`timescale 1ns / 100ps

module arp_receive_and_cache_test;
	import arpc_pkg::*;

	localparam int CACHE_SLOTS = 8;
	localparam int PERIOD      = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL        = 12;   // more addresses than slots, so entry 0 gets evicted
	localparam int LONG_HOLD   = 400;

	// one result word as the block presents it
	typedef struct packed {
		logic        consumed;
		logic        learned;
		logic        reply_needed;
		logic [47:0] reply_mac;
		logic [31:0] reply_ip;
		logic        hit;
		logic [47:0] found_mac;
	} arp_result_t;

	// Cache mirror plus the queue of result words still owed by the block.
	class arp_cache_scoreboard;
		logic [31:0] our_ip;
		logic [31:0] slot_ip [CACHE_SLOTS];
		logic [47:0] slot_mac [CACHE_SLOTS];
		bit          slot_valid [CACHE_SLOTS];
		arp_result_t awaited[$];
		int          errors;

		function new();
			our_ip = '0;
			errors = 0;
			foreach (slot_valid[i]) slot_valid[i] = 1'b0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Work out the result of an accepted input word and update the mirror.
		function void note_word(item_t w);
			arp_result_t r;
			int          slot;
			bit          have_free;
			bit          have_match;
			r          = '0;
			slot       = 0;
			have_free  = 1'b0;
			have_match = 1'b0;
			if (w.opcode == OPC_LOOKUP) begin
				// lowest valid slot with a matching address wins
				for (int i = 0; i < CACHE_SLOTS; i++) begin
					if (!r.hit && slot_valid[i] && slot_ip[i] == w.query_ip) begin
						r.hit       = 1'b1;
						r.found_mac = slot_mac[i];
					end
				end
			end else if (w.frame_length >= MIN_FRAME_LEN && w.ethertype == ETYPE_ARP) begin
				r.consumed = 1'b1;
				if (w.proto_type == PTYPE_IPV4 && w.hw_len == HW_ADDR_LEN &&
						w.proto_len == PROTO_ADDR_LEN) begin
					// matching entry first, else lowest free slot, else slot 0
					for (int i = 0; i < CACHE_SLOTS; i++) begin
						if (!have_match) begin
							if (slot_valid[i]) begin
								if (slot_ip[i] == w.sender_ip) begin
									slot       = i;
									have_match = 1'b1;
								end
							end else if (!have_free) begin
								slot      = i;
								have_free = 1'b1;
							end
						end
					end
					if (!have_match && !have_free)
						slot = 0;
					slot_ip[slot]    = w.sender_ip;
					slot_mac[slot]   = w.sender_mac;
					slot_valid[slot] = 1'b1;
					r.learned        = 1'b1;
					if (w.arp_oper == OPER_REQUEST && w.tgt_ip == our_ip) begin
						r.reply_needed = 1'b1;
						r.reply_mac    = w.sender_mac;
						r.reply_ip     = w.sender_ip;
					end
				end
			end
			awaited.push_back(r);
		endfunction

		function void diff(string field, logic [47:0] want, logic [47:0] got);
			if (got !== want) begin
				$error("%s: expected %h, actual %h", field, want, got);
				errors++;
			end
		endfunction

		function void check_word(arp_result_t got);
			arp_result_t want;
			if (awaited.size() == 0) begin
				$error("result word with no input word outstanding");
				errors++;
				return;
			end
			want = awaited.pop_front();
			diff("consumed", want.consumed, got.consumed);
			diff("learned", want.learned, got.learned);
			diff("reply_needed", want.reply_needed, got.reply_needed);
			diff("reply_mac", want.reply_mac, got.reply_mac);
			diff("reply_ip", want.reply_ip, got.reply_ip);
			diff("hit", want.hit, got.hit);
			diff("found_mac", want.found_mac, got.found_mac);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	arpc_item_if   item_ch ();
	arpc_result_if result_ch ();

	arp_receive_and_cache #(
		.ENTRIES(CACHE_SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(result_ch)
	);

	arp_cache_scoreboard sb = new();

	int          send_idle_pct  = 0;   // chance in a hundred that the sender skips a cycle
	int          stall_pct      = 0;   // chance in a hundred that the receiver stalls
	bit          hold_request   = 1'b0;
	int          cycle_count    = 0;
	logic [31:0] ip_pool [POOL];

	always #(PERIOD / 2) clk = ~clk;

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side. Everything is sampled right after the edge, so the values seen are the
	// ones the block presented at that edge. A long hold-off is counted here, on request
	// of the stimulus process.
	initial begin : result_sink
		int          hold_left;
		arp_result_t got;
		hold_left       = 0;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got = {result_ch.consumed, result_ch.learned, result_ch.reply_needed,
					result_ch.reply_mac, result_ch.reply_ip, result_ch.hit,
					result_ch.found_mac};
				sb.check_word(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one word; returns at the edge where it was taken. Valid stays high when the
	// next word follows without a gap.
	task automatic send_word(item_t w);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.opcode       <= w.opcode;
		item_ch.frame_length <= w.frame_length;
		item_ch.ethertype    <= w.ethertype;
		item_ch.proto_type   <= w.proto_type;
		item_ch.hw_len       <= w.hw_len;
		item_ch.proto_len    <= w.proto_len;
		item_ch.arp_oper     <= w.arp_oper;
		item_ch.sender_mac   <= w.sender_mac;
		item_ch.sender_ip    <= w.sender_ip;
		item_ch.tgt_ip       <= w.tgt_ip;
		item_ch.query_ip     <= w.query_ip;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_word(w);
	endtask

	// our_ip only changes with the block idle
	task automatic set_our_ip(logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.our_ip = v;
	endtask

	// Drop valid, wait for every owed result, then cover the block's own latency.
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (CACHE_SLOTS + 12) @(posedge clk);
	endtask

	function automatic item_t arp_frame(logic [15:0] oper, logic [31:0] sip,
			logic [47:0] smac, logic [31:0] tip);
		item_t w;
		w              = '0;
		w.opcode       = OPC_FRAME;
		w.frame_length = MIN_FRAME_LEN;
		w.ethertype    = ETYPE_ARP;
		w.proto_type   = PTYPE_IPV4;
		w.hw_len       = HW_ADDR_LEN;
		w.proto_len    = PROTO_ADDR_LEN;
		w.arp_oper     = oper;
		w.sender_mac   = smac;
		w.sender_ip    = sip;
		w.tgt_ip       = tip;
		return w;
	endfunction

	function automatic item_t lookup_word(logic [31:0] ip);
		item_t w;
		w          = '0;
		w.opcode   = OPC_LOOKUP;
		w.query_ip = ip;
		return w;
	endfunction

	function automatic logic [31:0] pick_ip();
		if ($urandom_range(9) == 0)
			return $urandom;
		return ip_pool[$urandom_range(POOL - 1)];
	endfunction

	// Random word: lookups and well-formed frames dominate, broken frames are the rest.
	// Fields a word ignores carry noise so every input bit toggles.
	function automatic item_t rand_word();
		item_t w;
		int    pick;
		w.opcode       = OPC_FRAME;
		w.frame_length = 16'($urandom);
		w.ethertype    = 16'($urandom);
		w.proto_type   = 16'($urandom);
		w.hw_len       = 8'($urandom);
		w.proto_len    = 8'($urandom);
		w.arp_oper     = 16'($urandom);
		w.sender_mac   = {16'($urandom), 32'($urandom)};
		w.sender_ip    = $urandom;
		w.tgt_ip       = $urandom;
		w.query_ip     = $urandom;
		pick = $urandom_range(99);
		if (pick < 40) begin
			w.opcode   = OPC_LOOKUP;
			w.query_ip = pick_ip();
		end else begin
			w.frame_length = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 42))
				: 16'($urandom_range(1518, 42));
			w.ethertype    = ETYPE_ARP;
			w.proto_type   = PTYPE_IPV4;
			w.hw_len       = HW_ADDR_LEN;
			w.proto_len    = PROTO_ADDR_LEN;
			case ($urandom_range(9))
				0:             w.arp_oper = 16'($urandom);
				1, 2, 3, 4, 5: w.arp_oper = OPER_REQUEST;
				default:       w.arp_oper = 16'd2;
			endcase
			w.sender_ip = pick_ip();
			w.tgt_ip    = $urandom_range(1) ? sb.our_ip : pick_ip();
			// broken frames: one header check fails
			if (pick >= 85) begin
				case ($urandom_range(4))
					0:       w.frame_length = 16'($urandom_range(41));
					1:       w.ethertype    = 16'($urandom);
					2:       w.proto_type   = 16'($urandom);
					3:       w.hw_len       = 8'($urandom);
					default: w.proto_len    = 8'($urandom);
				endcase
			end
		end
		return w;
	endfunction

	task automatic run_directed();
		item_t w;
		send_word(lookup_word(32'h0));                 // empty cache misses
		w = arp_frame(OPER_REQUEST, 32'h0A00_0001, 48'h1, 32'hFFFF_FFFF);
		w.frame_length = MIN_FRAME_LEN - 16'd1;        // one byte short
		send_word(w);
		w.frame_length = 16'd0;
		send_word(w);
		w = arp_frame(OPER_REQUEST, 32'h0A00_0001, 48'h1, 32'hFFFF_FFFF);
		w.ethertype = PTYPE_IPV4;                      // not ARP at all
		send_word(w);
		// consumed but ignored: bad protocol type, bad address lengths
		w = arp_frame(OPER_REQUEST, 32'h0A00_0001, 48'h1, 32'hFFFF_FFFF);
		w.frame_length = 16'hFFFF;
		w.proto_type   = 16'hFFFF;
		send_word(w);
		w = arp_frame(OPER_REQUEST, 32'h0A00_0001, 48'h1, 32'hFFFF_FFFF);
		w.hw_len = 8'd0;
		send_word(w);
		w = arp_frame(OPER_REQUEST, 32'h0A00_0001, 48'h1, 32'hFFFF_FFFF);
		w.proto_len = 8'hFF;
		send_word(w);
		send_word(lookup_word(32'h0A00_0001));         // nothing was learned above
		// request to us from address 0: learn and reply
		send_word(arp_frame(OPER_REQUEST, 32'h0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
		// same sender, new MAC, not for us: entry updated in place
		send_word(arp_frame(OPER_REQUEST, 32'h0, 48'h0123_4567_89AB, 32'h0A00_00FE));
		// aimed at us but not a request: no reply
		send_word(arp_frame(16'd2, 32'hFFFF_FFFF, 48'h0, 32'hFFFF_FFFF));
		send_word(arp_frame(16'hFFFF, 32'hFFFF_FFFF, 48'h0, 32'hFFFF_FFFF));
		send_word(lookup_word(32'h0));                 // hit with the updated MAC
		// fill the remaining slots, the last one evicts slot 0
		for (int i = 1; i <= 7; i++)
			send_word(arp_frame(16'd2, 32'h0A00_0000 + i, 48'hAA00_0000_0000 + i, 32'h0));
		send_word(lookup_word(32'h0));                 // evicted
		send_word(lookup_word(32'h0A00_0007));         // sits in slot 0 now
	endtask

	task automatic run_random(int count);
		repeat (count) send_word(rand_word());
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		item_ch.valid        = 1'b0;
		item_ch.opcode       = OPC_FRAME;
		item_ch.frame_length = '0;
		item_ch.ethertype    = '0;
		item_ch.proto_type   = '0;
		item_ch.hw_len       = '0;
		item_ch.proto_len    = '0;
		item_ch.arp_oper     = '0;
		item_ch.sender_mac   = '0;
		item_ch.sender_ip    = '0;
		item_ch.tgt_ip       = '0;
		item_ch.query_ip     = '0;
		// address pool with both extremes, the rest random
		ip_pool[0] = 32'h0;
		ip_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL; i++)
			ip_pool[i] = $urandom;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed words, no idling on either side
		set_our_ip(32'hFFFF_FFFF);
		run_directed();
		wait_drained();

		// Phase 1: no idling. The receiver holds off for a long stretch right away, so
		// the block fills and backs up its input while words keep coming.
		set_our_ip(32'h0);
		hold_request = 1'b1;
		run_random(170);
		wait_drained();   // sender pauses until nothing is owed

		// Phase 2: sparse sender
		set_our_ip($urandom);
		send_idle_pct = 88;
		stall_pct     = 0;
		run_random(170);
		wait_drained();

		// Phase 3: slow receiver
		set_our_ip(32'hFFFF_FFFF);
		send_idle_pct = 0;
		stall_pct     = 88;
		run_random(170);
		wait_drained();

		// Phase 4: both sides idle now and then; our_ip taken from the pool so replies
		// also come from addresses already cached
		set_our_ip(ip_pool[$urandom_range(POOL - 1)]);
		send_idle_pct = 31;
		stall_pct     = 31;
		run_random(170);
		wait_drained();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/arpc_pkg.sv
sv/arpc_if.sv
sv/arpc_cell.sv
sv/arp_receive_and_cache.sv
tb/sv/arp_receive_and_cache_test.sv
